// ===== rtl/adb_pkg.sv =====
// ----------------------------------------------------------------------------
// adb_pkg
// Shared types and constants for the ADB mouse and keyboard device.
// ----------------------------------------------------------------------------
package adb_pkg;

   // Input item opcodes.
   localparam logic [2:0] OPC_BUS     = 3'd0;
   localparam logic [2:0] OPC_KEYDOWN = 3'd1;
   localparam logic [2:0] OPC_KEYUP   = 3'd2;
   localparam logic [2:0] OPC_MOVE    = 3'd3;
   localparam logic [2:0] OPC_BUTTON  = 3'd4;
   localparam logic [2:0] OPC_TICK    = 3'd5;

   // Result kinds.
   localparam logic [1:0] KIND_TALK   = 2'd0;
   localparam logic [1:0] KIND_MOUSE  = 2'd1;
   localparam logic [1:0] KIND_KEY    = 2'd2;
   localparam logic [1:0] KIND_CURSOR = 2'd3;

   // ADB command codes.
   localparam logic [1:0] CMD_LISTEN = 2'd2;
   localparam logic [1:0] CMD_TALK   = 2'd3;

   // Configuration register indexes.
   localparam logic [0:0] CSR_KBD_TYPE = 1'd0;
   localparam logic [0:0] CSR_MOUSE_REL = 1'd1;

   localparam int unsigned KEY_FIFO_DEPTH_DEF = 16;

   // One classified item handed from the front part to the back part.
   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  command_byte;
      logic [7:0]  listen_byte1;
      logic [7:0]  listen_byte2;
      logic [3:0]  random_nibble;
      logic [6:0]  key_code;
      logic [1:0]  button_index;
      logic        pressed;
      logic [15:0] move_x;
      logic [15:0] move_y;
   } item_type;

endpackage

// ===== rtl/adb_mouse_keyboard_device.sv =====
// ----------------------------------------------------------------------------
// adb_mouse_keyboard_device
// ADB mouse and keyboard emulation: bus commands, key and mouse events, ticks.
// ----------------------------------------------------------------------------
// An item is accepted when start is high and busy is low; busy rises while
// the two-entry input queue is full. A non-tick item is handled in the idle
// state of the back part; its result, if any, goes to the result registers.
// A tick steps through the mouse state in relative mode and the cursor and
// mouse states in absolute mode, then a read state and an output state per
// queued key event, set by the registered read of the key FIFO memory.
// Results appear on rsp_* for one cycle with rsp_valid high and cannot be
// stalled; rsp_last marks the final result of an item. Configuration writes
// are taken at any time and should be made only while no item is in flight.
module adb_mouse_keyboard_device
   import adb_pkg::*;
#(
   parameter int unsigned KEY_FIFO_DEPTH = KEY_FIFO_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_command_byte,
   input  logic [7:0]  req_listen_byte1,
   input  logic [7:0]  req_listen_byte2,
   input  logic [3:0]  req_random_nibble,
   input  logic [6:0]  req_key_code,
   input  logic [1:0]  req_button_index,
   input  logic        req_pressed,
   input  logic signed [15:0] req_move_x,
   input  logic signed [15:0] req_move_y,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_target_command,
   output logic [3:0]  rsp_byte_count,
   output logic [7:0]  rsp_data0,
   output logic [7:0]  rsp_data1,
   output logic [7:0]  rsp_data2,
   output logic [7:0]  rsp_data3,
   output logic [7:0]  rsp_data4,
   output logic [7:0]  rsp_data5,
   output logic [7:0]  rsp_data6,
   output logic [7:0]  rsp_data7,
   output logic        rsp_last
);

   item_type   req_item, head;
   logic       full, avail, pop, idle;
   logic [7:0] data [8];

   assign req_item = '{req_opcode, req_command_byte, req_listen_byte1, req_listen_byte2,
                       req_random_nibble, req_key_code, req_button_index, req_pressed,
                       req_move_x, req_move_y};
   assign busy      = full;
   assign csr_ready = 1'b1;

   adb_front u_front (
      .clock(clock), .reset(reset), .push(start && !busy), .push_item(req_item),
      .full(full), .pop(pop), .avail(avail), .head(head)
   );

   adb_back #(.KEY_FIFO_DEPTH(KEY_FIFO_DEPTH)) u_back (
      .clock(clock), .reset(reset), .avail(avail), .head(head), .pop(pop), .idle(idle),
      .cfg_we(csr_valid && csr_ready), .cfg_idx(csr_index), .cfg_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_target_command(rsp_target_command),
      .rsp_byte_count(rsp_byte_count), .rsp_data(data), .rsp_last(rsp_last)
   );

   assign rsp_data0 = data[0];
   assign rsp_data1 = data[1];
   assign rsp_data2 = data[2];
   assign rsp_data3 = data[3];
   assign rsp_data4 = data[4];
   assign rsp_data5 = data[5];
   assign rsp_data6 = data[6];
   assign rsp_data7 = data[7];

   // The queue never pops while empty.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> avail) else $error("pop from empty queue");
   // The queue is never full while the back part is idle.
   assert property (@(posedge clock) disable iff (reset)
      idle |-> !busy) else $error("busy while idle");
   // Busy only follows a queue that was filled.
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start)) else $error("busy without accepted item");

endmodule

// ===== rtl/adb_front.sv =====
// ----------------------------------------------------------------------------
// adb_front
// Accepts items and holds them in a short queue for the back part.
// ----------------------------------------------------------------------------
module adb_front
   import adb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     avail,
   output item_type head
);

   // Two-entry queue.
   item_type   slot_ff [2];
   item_type   slot_in [2];
   logic [1:0] count_ff, count_in;

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (pop && count_ff != 2'd0) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_in - 2'd1;
      end
      if (push) begin
         slot_in[count_in[0]] = push_item;
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign full  = count_ff[1];
   assign avail = count_ff != 2'd0;
   assign head  = slot_ff[0];

endmodule

// ===== rtl/adb_back.sv =====
// ----------------------------------------------------------------------------
// adb_back
// Executes items: device registers, key matrix, key FIFO, mouse state, and
// result sequencing.
// ----------------------------------------------------------------------------
module adb_back
   import adb_pkg::*;
#(
   parameter int unsigned KEY_FIFO_DEPTH = KEY_FIFO_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       avail,
   input  item_type   head,
   output logic       pop,
   output logic       idle,
   input  logic       cfg_we,
   input  logic       cfg_idx,
   input  logic [7:0] cfg_data,
   output logic       rsp_valid,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_target_command,
   output logic [3:0] rsp_byte_count,
   output logic [7:0] rsp_data [8],
   output logic       rsp_last
);

   localparam int unsigned PW = (KEY_FIFO_DEPTH > 1) ? $clog2(KEY_FIFO_DEPTH) : 1;
   localparam int unsigned CW = $clog2(KEY_FIFO_DEPTH + 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CURSOR = 5'b00010,
      ST_MOUSE  = 5'b00100,
      ST_KEYRD  = 5'b01000,
      ST_KEYOUT = 5'b10000
   } state_type;

   state_type   state_ff;
   logic [7:0]  kbd_type_ff, mouse_adr_ff, mouse_hid_ff, kbd_adr_ff, leds_hi_ff, leds_lo_ff;
   logic        rel_ff;
   logic [127:0] matrix_ff;
   logic [PW-1:0] rd_ptr_ff, wr_ptr_ff;
   logic [CW-1:0] cnt_ff;
   logic [15:0] mx_ff, my_ff, lx_ff, ly_ff;
   logic [2:0]  bn_ff, brep_ff;

   // Result registers and their next values.
   logic        rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_tc_ff, rsp_tc_in;
   logic [3:0]  rsp_cnt_ff, rsp_cnt_in;
   logic [7:0]  rsp_data_ff [8];
   logic [7:0]  rsp_data_in [8];

   // Key FIFO storage.
   logic          fifo_we;
   logic [7:0]    fifo_wdata, fifo_rdata;
   adb_ram #(.WIDTH(8), .DEPTH(KEY_FIFO_DEPTH)) u_fifo (
      .clock(clock), .we(fifo_we), .waddr(wr_ptr_ff), .wdata(fifo_wdata),
      .raddr(rd_ptr_ff), .rdata(fifo_rdata)
   );

   logic [3:0] adr;
   logic [1:0] cmd, rg;
   logic       hit_m, hit_k, fifo_full;
   logic [7:0] hi_b, lo_b, ktc, mtc;
   logic [2:0] bn;
   logic [3:0] mcnt;

   assign adr   = head.command_byte[7:4];
   assign cmd   = head.command_byte[3:2];
   assign rg    = head.command_byte[1:0];
   assign hit_m = adr == mouse_adr_ff[3:0];
   assign hit_k = !hit_m && adr == kbd_adr_ff[3:0];
   assign fifo_full = cnt_ff == CW'(KEY_FIFO_DEPTH);
   assign ktc   = {kbd_adr_ff[3:0], 4'hc};
   assign mtc   = {mouse_adr_ff[3:0], 4'hc};
   assign bn    = bn_ff;
   assign mcnt  = (mouse_hid_ff == 8'd4) ? 4'd3 : 4'd2;

   // Keyboard register 2 status bytes.
   always_comb begin
      hi_b = 8'hff;
      lo_b = leds_lo_ff | 8'hf8;
      if (matrix_ff[7'h6b]) lo_b[6] = 1'b0;
      if (matrix_ff[7'h47]) lo_b[7] = 1'b0;
      if (matrix_ff[7'h37]) hi_b[0] = 1'b0;
      if (matrix_ff[7'h3a]) hi_b[1] = 1'b0;
      if (matrix_ff[7'h38]) hi_b[2] = 1'b0;
      if (matrix_ff[7'h36]) hi_b[3] = 1'b0;
      if (matrix_ff[7'h39]) hi_b[5] = 1'b0;
      if (matrix_ff[7'h75]) hi_b[6] = 1'b0;
   end

   logic start;
   assign start = state_ff == ST_IDLE && avail;
   assign pop   = start;
   assign idle  = state_ff == ST_IDLE && !avail;

   logic key_ev;
   assign key_ev = start && (head.opcode == OPC_KEYDOWN || head.opcode == OPC_KEYUP);
   assign fifo_we    = key_ev && !fifo_full;
   assign fifo_wdata = {head.opcode == OPC_KEYUP, head.key_code};

   logic mouse_chg, cur_chg;
   assign cur_chg   = mx_ff != lx_ff || my_ff != ly_ff;
   assign mouse_chg = bn != brep_ff;

   // Result produced by the current state: talk replies, reports and key drain.
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_kind_in  = KIND_TALK;
      rsp_tc_in    = head.command_byte;
      rsp_cnt_in   = 4'd0;
      rsp_data_in  = '{default: 8'h00};
      unique case (state_ff)
         ST_IDLE: begin
            // Every talk command gets a reply, empty when nothing answers.
            if (start && head.opcode == OPC_BUS && cmd == CMD_TALK) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (hit_m) begin
                  if (rg == 2'd1) begin
                     rsp_cnt_in  = 4'd8;
                     rsp_data_in = '{8'h61, 8'h70, 8'h70, 8'h6c, 8'd1, 8'd44, 8'd1, 8'd3};
                  end else if (rg == 2'd3) begin
                     rsp_cnt_in     = 4'd2;
                     rsp_data_in[0] = {mouse_adr_ff[7:4], head.random_nibble};
                     rsp_data_in[1] = mouse_hid_ff;
                  end
               end else if (hit_k) begin
                  if (rg == 2'd2) begin
                     rsp_cnt_in     = 4'd2;
                     rsp_data_in[0] = hi_b;
                     rsp_data_in[1] = lo_b;
                  end else if (rg == 2'd3) begin
                     rsp_cnt_in     = 4'd2;
                     rsp_data_in[0] = {kbd_adr_ff[7:4], head.random_nibble};
                     rsp_data_in[1] = kbd_type_ff;
                  end
               end
            end
         end
         ST_CURSOR: begin
            rsp_valid_in = cur_chg;
            rsp_last_in  = cur_chg && !mouse_chg && cnt_ff == '0;
            rsp_kind_in  = KIND_CURSOR;
            rsp_tc_in    = 8'd0;
            rsp_cnt_in   = 4'd4;
            rsp_data_in  = '{mx_ff[15:8], mx_ff[7:0], my_ff[15:8], my_ff[7:0],
                             8'd0, 8'd0, 8'd0, 8'd0};
         end
         ST_MOUSE: begin
            rsp_valid_in = rel_ff ? (mx_ff != '0 || my_ff != '0 || mouse_chg) : mouse_chg;
            rsp_last_in  = rsp_valid_in && cnt_ff == '0;
            rsp_kind_in  = KIND_MOUSE;
            rsp_tc_in    = mtc;
            rsp_cnt_in   = mcnt;
            rsp_data_in[0] = (rel_ff ? {1'b0, my_ff[6:0]} : 8'd0) | (bn[0] ? 8'h00 : 8'h80);
            rsp_data_in[1] = (rel_ff ? {1'b0, mx_ff[6:0]} : 8'd0) | (bn[1] ? 8'h00 : 8'h80);
            if (mcnt == 4'd3)
               rsp_data_in[2] = (rel_ff ? {1'b0, my_ff[9:7], 1'b0, mx_ff[9:7]} : 8'd0)
                                | (bn[2] ? 8'h08 : 8'h88);
         end
         ST_KEYRD: ;
         ST_KEYOUT: begin
            rsp_valid_in   = 1'b1;
            rsp_last_in    = cnt_ff == CW'(1);
            rsp_kind_in    = KIND_KEY;
            rsp_tc_in      = ktc;
            rsp_cnt_in     = 4'd2;
            rsp_data_in[0] = fifo_rdata;
            rsp_data_in[1] = (fifo_rdata == 8'h7f) ? 8'h7f : 8'hff;
         end
         default: ;
      endcase
   end

   // Result registers.
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_tc_ff   <= rsp_tc_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_target_command = rsp_tc_ff;
   assign rsp_byte_count     = rsp_cnt_ff;
   assign rsp_data           = rsp_data_ff;

   // Main sequencer and state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kbd_type_ff <= 8'd5; rel_ff <= 1'b0;
         mouse_adr_ff <= 8'h63; mouse_hid_ff <= 8'h01; kbd_adr_ff <= 8'h62;
         leds_hi_ff <= 8'hff; leds_lo_ff <= 8'hff;
         matrix_ff <= '0; rd_ptr_ff <= '0; wr_ptr_ff <= '0; cnt_ff <= '0;
         mx_ff <= '0; my_ff <= '0; lx_ff <= '0; ly_ff <= '0;
         bn_ff <= '0; brep_ff <= '0;
      end else begin
         if (cfg_we) begin
            if (cfg_idx == CSR_KBD_TYPE) begin
               kbd_type_ff <= cfg_data;
            end else if (cfg_data[0] != rel_ff) begin
               rel_ff <= cfg_data[0]; mx_ff <= '0; my_ff <= '0;
            end
         end
         if (fifo_we) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(KEY_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
            cnt_ff <= cnt_ff + 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  case (head.opcode)
                     OPC_BUS: begin
                        if (head.command_byte[3:0] == 4'd0) begin
                           mouse_adr_ff <= 8'h63; mouse_hid_ff <= 8'h01;
                           kbd_adr_ff <= 8'h62; leds_hi_ff <= 8'hff; leds_lo_ff <= 8'hff;
                        end else if (hit_m) begin
                           if (cmd == CMD_LISTEN && rg == 2'd3) begin
                              if (head.listen_byte2 == 8'hfe)
                                 mouse_adr_ff[3:0] <= head.listen_byte1[3:0];
                              else if (head.listen_byte2 == 8'd1 || head.listen_byte2 == 8'd2
                                       || head.listen_byte2 == 8'd4)
                                 mouse_hid_ff <= head.listen_byte2;
                              else if (head.listen_byte2 == 8'd0)
                                 mouse_adr_ff <= (mouse_adr_ff & 8'hd0) | (head.listen_byte1 & 8'h2f);
                           end
                        end else if (hit_k) begin
                           if (cmd == CMD_LISTEN && rg == 2'd2) begin
                              leds_hi_ff <= head.listen_byte1; leds_lo_ff <= head.listen_byte2;
                           end else if (cmd == CMD_LISTEN && rg == 2'd3) begin
                              if (head.listen_byte2 == 8'hfe)
                                 kbd_adr_ff[3:0] <= head.listen_byte1[3:0];
                              else if (head.listen_byte2 == 8'd0)
                                 kbd_adr_ff <= (kbd_adr_ff & 8'hd0) | (head.listen_byte1 & 8'h2f);
                           end
                        end
                     end
                     OPC_KEYDOWN: matrix_ff[head.key_code] <= 1'b1;
                     OPC_KEYUP:   matrix_ff[head.key_code] <= 1'b0;
                     OPC_MOVE: begin
                        mx_ff <= rel_ff ? mx_ff + head.move_x : head.move_x;
                        my_ff <= rel_ff ? my_ff + head.move_y : head.move_y;
                     end
                     OPC_BUTTON: begin
                        if (head.button_index != 2'd3)
                           bn_ff[head.button_index] <= head.pressed;
                     end
                     OPC_TICK: state_ff <= rel_ff ? ST_MOUSE : ST_CURSOR;
                     default: ;
                  endcase
               end
            end
            ST_CURSOR: begin
               if (cur_chg) begin
                  lx_ff <= mx_ff; ly_ff <= my_ff;
               end
               state_ff <= ST_MOUSE;
            end
            ST_MOUSE: begin
               if (rsp_valid_in) begin
                  brep_ff <= bn;
               end
               if (rel_ff) begin
                  mx_ff <= '0; my_ff <= '0;
               end
               state_ff <= (cnt_ff == '0) ? ST_IDLE : ST_KEYRD;
            end
            ST_KEYRD: state_ff <= ST_KEYOUT;
            ST_KEYOUT: begin
               rd_ptr_ff <= (rd_ptr_ff == PW'(KEY_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
               cnt_ff <= cnt_ff - 1'b1;
               state_ff <= (cnt_ff == CW'(1)) ? ST_IDLE : ST_KEYRD;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // A result never follows the key read state; results come from bus commands and ticks.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) != ST_KEYRD) else $error("result from read state");
   // The key FIFO count never exceeds its depth.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(KEY_FIFO_DEPTH)) else $error("fifo overflow");
   // Key drain only happens with stored events.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_KEYOUT |-> cnt_ff != '0) else $error("drain of empty fifo");

endmodule

// ===== rtl/adb_ram.sv =====
// ----------------------------------------------------------------------------
// adb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module adb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// ===== tb/adb_mouse_keyboard_device_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adb_mouse_keyboard_device_test
// Self-checking testbench for the ADB mouse and keyboard device. A behavioral
// model of the device predicts every talk reply, mouse report, key report and
// cursor position. Results are compared field by field in arrival order.
// Directed tests cover bus commands, the key FIFO and both mouse modes.
// A long random test follows, with random gaps on the request side and
// configuration changes between phases.
// ----------------------------------------------------------------------------
module adb_mouse_keyboard_device_test;
   import adb_pkg::*;

   // Opcodes and command codes the package does not name.
   localparam logic [2:0] OPC_SPARE_A  = 3'd6;
   localparam logic [2:0] OPC_SPARE_B  = 3'd7;
   localparam logic [1:0] CMD_RESET    = 2'd0;
   localparam logic [1:0] CMD_RESERVED = 2'd1;
   localparam int FIFO_DEPTH   = KEY_FIFO_DEPTH_DEF;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] target;
      logic [3:0] count;
      logic [7:0] data [8];
      logic       last;
   } report_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_opcode;
   logic [7:0]  req_command_byte;
   logic [7:0]  req_listen_byte1;
   logic [7:0]  req_listen_byte2;
   logic [3:0]  req_random_nibble;
   logic [6:0]  req_key_code;
   logic [1:0]  req_button_index;
   logic        req_pressed;
   logic signed [15:0] req_move_x;
   logic signed [15:0] req_move_y;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [7:0]  csr_data;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_target_command;
   logic [3:0]  rsp_byte_count;
   logic [7:0]  rsp_data0, rsp_data1, rsp_data2, rsp_data3;
   logic [7:0]  rsp_data4, rsp_data5, rsp_data6, rsp_data7;
   logic        rsp_last;

   // Device state as the testbench sees it.
   logic [7:0]   kbd_type;
   logic         mouse_rel;
   logic [7:0]   mouse_addr, mouse_handler, kbd_addr, leds_high, leds_low;
   logic [127:0] keys_down;
   logic [7:0]   key_events [$];
   logic [15:0]  mouse_x, mouse_y, last_x, last_y;
   logic [2:0]   buttons_now, buttons_reported;

   report_type expected_reports [$];
   int      error_count;

   adb_mouse_keyboard_device dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic void add_report(logic [1:0] kind, logic [7:0] target,
                                      logic [3:0] count, logic [7:0] b [8]);
      report_type r;
      r.kind   = kind;
      r.target = target;
      r.count  = count;
      for (int i = 0; i < 8; i++)
         r.data[i] = (i < count) ? b[i] : 8'h00;
      r.last = 1'b0;
      expected_reports.push_back(r);
   endfunction

   function automatic void restore_device_regs();
      mouse_addr    = 8'h63;
      mouse_handler = 8'h01;
      kbd_addr      = 8'h62;
      leds_high     = 8'hff;
      leds_low      = 8'hff;
   endfunction

   function automatic void queue_key_event(logic [7:0] code);
      if (key_events.size() < FIFO_DEPTH)
         key_events.push_back(code);
   endfunction

   function automatic int predict_bus_command(item_type it);
      logic [7:0] op;
      logic [3:0] adr;
      logic [1:0] cmd, rg;
      logic [7:0] b [8];
      logic [3:0] cnt;
      op  = it.command_byte;
      adr = op[7:4];
      cmd = op[3:2];
      rg  = op[1:0];
      cnt = 0;
      foreach (b[i]) b[i] = 8'h00;
      if (op[3:0] == 4'h0) begin
         restore_device_regs();
         return 0;
      end
      if (adr == mouse_addr[3:0]) begin
         if (cmd == CMD_LISTEN) begin
            if (rg == 2'd3) begin
               if (it.listen_byte2 == 8'hfe)
                  mouse_addr = {mouse_addr[7:4], it.listen_byte1[3:0]};
               else if (it.listen_byte2 inside {8'd1, 8'd2, 8'd4})
                  mouse_handler = it.listen_byte2;
               else if (it.listen_byte2 == 8'h00)
                  mouse_addr = (mouse_addr & 8'hd0) | (it.listen_byte1 & 8'h2f);
            end
            return 0;
         end
         if (cmd != CMD_TALK) return 0;
         if (rg == 2'd1) begin
            b = '{8'h61, 8'h70, 8'h70, 8'h6c, 8'h01, 8'h2c, 8'h01, 8'h03};
            cnt = 8;
         end else if (rg == 2'd3) begin
            b[0] = {mouse_addr[7:4], it.random_nibble};
            b[1] = mouse_handler;
            cnt = 2;
         end
      end else if (adr == kbd_addr[3:0]) begin
         if (cmd == CMD_LISTEN) begin
            if (rg == 2'd2) begin
               leds_high = it.listen_byte1;
               leds_low  = it.listen_byte2;
            end else if (rg == 2'd3) begin
               if (it.listen_byte2 == 8'hfe)
                  kbd_addr = {kbd_addr[7:4], it.listen_byte1[3:0]};
               else if (it.listen_byte2 == 8'h00)
                  kbd_addr = (kbd_addr & 8'hd0) | (it.listen_byte1 & 8'h2f);
            end
            return 0;
         end
         if (cmd != CMD_TALK) return 0;
         if (rg == 2'd2) begin
            // Modifier keys held down clear their bits in register 2.
            b[0] = 8'hff;
            b[1] = leds_low | 8'hf8;
            if (keys_down[7'h6b]) b[1][6] = 1'b0;
            if (keys_down[7'h47]) b[1][7] = 1'b0;
            if (keys_down[7'h37]) b[0][0] = 1'b0;
            if (keys_down[7'h3a]) b[0][1] = 1'b0;
            if (keys_down[7'h38]) b[0][2] = 1'b0;
            if (keys_down[7'h36]) b[0][3] = 1'b0;
            if (keys_down[7'h39]) b[0][5] = 1'b0;
            if (keys_down[7'h75]) b[0][6] = 1'b0;
            cnt = 2;
         end else if (rg == 2'd3) begin
            b[0] = {kbd_addr[7:4], it.random_nibble};
            b[1] = kbd_type;
            cnt = 2;
         end
      end else if (cmd != CMD_TALK) begin
         return 0;
      end
      add_report(KIND_TALK, op, cnt, b);
      return 1;
   endfunction

   function automatic int predict_tick();
      logic [15:0] mx, my;
      logic [2:0]  bn;
      logic [7:0]  b [8];
      logic [3:0]  mcnt;
      logic [7:0]  code;
      int n;
      mx = mouse_x;
      my = mouse_y;
      bn = buttons_now;
      mcnt = (mouse_handler == 8'd4) ? 4'd3 : 4'd2;
      n = 0;
      foreach (b[i]) b[i] = 8'h00;
      if (mouse_rel) begin
         mouse_x = 0;
         mouse_y = 0;
         if (mx != 0 || my != 0 || bn != buttons_reported) begin
            b[0] = {~bn[0], my[6:0]};
            b[1] = {~bn[1], mx[6:0]};
            b[2] = {1'b0, my[9:7], 1'b1, mx[9:7]};
            b[2][7] = ~bn[2];
            add_report(KIND_MOUSE, {mouse_addr[3:0], 4'hc}, mcnt, b);
            buttons_reported = bn;
            n++;
         end
      end else begin
         if (mx != last_x || my != last_y) begin
            b[0] = mx[15:8];
            b[1] = mx[7:0];
            b[2] = my[15:8];
            b[3] = my[7:0];
            add_report(KIND_CURSOR, 8'h00, 4'd4, b);
            last_x = mx;
            last_y = my;
            n++;
         end
         if (bn != buttons_reported) begin
            b[0] = {~bn[0], 7'd0};
            b[1] = {~bn[1], 7'd0};
            b[2] = {~bn[2], 3'd0, 1'b1, 3'd0};
            add_report(KIND_MOUSE, {mouse_addr[3:0], 4'hc}, mcnt, b);
            buttons_reported = bn;
            n++;
         end
      end
      // Drain the key events as key reports.
      while (key_events.size() > 0) begin
         code = key_events.pop_front();
         b[0] = code;
         b[1] = (code == 8'h7f) ? 8'h7f : 8'hff;
         add_report(KIND_KEY, {kbd_addr[3:0], 4'hc}, 4'd2, b);
         n++;
      end
      return n;
   endfunction

   function automatic void predict_item(item_type it);
      int n;
      n = 0;
      case (it.opcode)
         OPC_BUS: n = predict_bus_command(it);
         OPC_KEYDOWN: begin
            queue_key_event({1'b0, it.key_code});
            keys_down[it.key_code] = 1'b1;
         end
         OPC_KEYUP: begin
            queue_key_event({1'b1, it.key_code});
            keys_down[it.key_code] = 1'b0;
         end
         OPC_MOVE: begin
            if (mouse_rel) begin
               mouse_x = mouse_x + it.move_x;
               mouse_y = mouse_y + it.move_y;
            end else begin
               mouse_x = it.move_x;
               mouse_y = it.move_y;
            end
         end
         OPC_BUTTON: begin
            if (it.button_index != 2'd3)
               buttons_now[it.button_index] = it.pressed;
         end
         OPC_TICK: n = predict_tick();
         default: ;
      endcase
      if (n > 0)
         expected_reports[expected_reports.size() - 1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------
   function automatic void compare_field(string name, logic [7:0] exp_v,
                                         logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%02h, actual 0x%02h", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      report_type r;
      logic [7:0] act [8];
      if (!reset && rsp_valid) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected result transfer, kind %0d", rsp_kind);
            error_count++;
         end else begin
            r = expected_reports.pop_front();
            act = '{rsp_data0, rsp_data1, rsp_data2, rsp_data3,
                    rsp_data4, rsp_data5, rsp_data6, rsp_data7};
            compare_field("kind", r.kind, rsp_kind);
            compare_field("target_command", r.target, rsp_target_command);
            compare_field("byte_count", r.count, rsp_byte_count);
            for (int i = 0; i < 8; i++)
               compare_field($sformatf("data%0d", i), r.data[i], act[i]);
            compare_field("last", r.last, rsp_last);
         end
      end
   end

   // ------------------------------------------------------------------
   // Request and configuration transfers
   // ------------------------------------------------------------------
   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Start stays high across back-to-back transfers.
   task automatic send_item(item_type it, bit allow_gap = 1);
      int gap;
      req_opcode        <= it.opcode;
      req_command_byte  <= it.command_byte;
      req_listen_byte1  <= it.listen_byte1;
      req_listen_byte2  <= it.listen_byte2;
      req_random_nibble <= it.random_nibble;
      req_key_code      <= it.key_code;
      req_button_index  <= it.button_index;
      req_pressed       <= it.pressed;
      req_move_x        <= it.move_x;
      req_move_y        <= it.move_y;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      predict_item(it);
      gap = allow_gap ? pick_gap() : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic item_type blank_item(logic [2:0] opc);
      item_type it;
      it = '0;
      it.opcode = opc;
      return it;
   endfunction

   task automatic send_bus(logic [3:0] adr, logic [1:0] cmd, logic [1:0] rg,
                           logic [7:0] b1 = 8'h00, logic [7:0] b2 = 8'h00,
                           logic [3:0] rnd = 4'h0);
      item_type it;
      it = blank_item(OPC_BUS);
      it.command_byte  = {adr, cmd, rg};
      it.listen_byte1  = b1;
      it.listen_byte2  = b2;
      it.random_nibble = rnd;
      send_item(it);
   endtask

   task automatic send_key(logic [2:0] opc, logic [6:0] code);
      item_type it;
      it = blank_item(opc);
      it.key_code = code;
      send_item(it);
   endtask

   task automatic send_move(logic [15:0] x, logic [15:0] y);
      item_type it;
      it = blank_item(OPC_MOVE);
      it.move_x = x;
      it.move_y = y;
      send_item(it);
   endtask

   task automatic send_button(logic [1:0] idx, logic p);
      item_type it;
      it = blank_item(OPC_BUTTON);
      it.button_index = idx;
      it.pressed = p;
      send_item(it);
   endtask

   // Lower start, let every expected result arrive, then let the block settle.
   task automatic wait_idle();
      int cycles;
      start <= 1'b0;
      cycles = 0;
      while (expected_reports.size() != 0 && cycles < 20000) begin
         @(posedge clock);
         cycles++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_KBD_TYPE) begin
         kbd_type = value;
      end else if (value[0] != mouse_rel) begin
         mouse_rel = value[0];
         mouse_x = 0;
         mouse_y = 0;
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_bus_commands();
      send_bus(4'h3, CMD_TALK, 2'd1);                    // mouse identity
      send_bus(4'h3, CMD_TALK, 2'd3, 8'h00, 8'h00, 4'hf);
      send_bus(4'h2, CMD_TALK, 2'd3, 8'h00, 8'h00, 4'h0);
      send_bus(4'h2, CMD_LISTEN, 2'd2, 8'h00, 8'h00);    // LEDs
      send_bus(4'h2, CMD_TALK, 2'd2);
      send_bus(4'h3, CMD_LISTEN, 2'd3, 8'h00, 8'd4);     // extended handler
      send_bus(4'h3, CMD_LISTEN, 2'd3, 8'hff, 8'h55);    // unknown handler
      send_bus(4'h3, CMD_LISTEN, 2'd1, 8'hff, 8'hfe);    // unused register
      send_bus(4'h3, CMD_LISTEN, 2'd3, 8'h0a, 8'hfe);    // mouse moves to 0xa
      send_bus(4'ha, CMD_TALK, 2'd3, 8'h00, 8'h00, 4'h5);
      send_bus(4'ha, CMD_TALK, 2'd0);                    // unused register
      send_bus(4'h7, CMD_TALK, 2'd1);                    // unknown address
      send_bus(4'h7, CMD_LISTEN, 2'd3, 8'h01, 8'hfe);
      send_bus(4'h2, CMD_LISTEN, 2'd3, 8'hff, 8'h00);    // keyboard address bits
      send_bus(4'hf, CMD_TALK, 2'd3, 8'h00, 8'h00, 4'ha);
      send_bus(4'hf, CMD_RESERVED, 2'd2);                // no effect
      send_bus(4'hf, CMD_RESET, 2'd1);                   // flush
      send_bus(4'h5, CMD_RESET, 2'd0);                   // bus reset
      send_bus(4'h3, CMD_TALK, 2'd3, 8'h00, 8'h00, 4'h1);
      send_bus(4'h2, CMD_TALK, 2'd3, 8'h00, 8'h00, 4'h2);
      wait_idle();
   endtask

   task automatic test_key_fifo();
      send_item(blank_item(OPC_TICK));                   // nothing to report
      send_key(OPC_KEYDOWN, 7'h37);
      send_key(OPC_KEYDOWN, 7'h7f);
      send_key(OPC_KEYDOWN, 7'h00);
      send_bus(4'h2, CMD_TALK, 2'd2);
      send_key(OPC_KEYUP, 7'h7f);
      send_item(blank_item(OPC_TICK));
      // Overfill the FIFO; the extra events are dropped.
      for (int i = 0; i < FIFO_DEPTH + 3; i++)
         send_key((i % 2) ? OPC_KEYUP : OPC_KEYDOWN, 7'(i * 9));
      send_button(2'd0, 1'b1);
      send_move(16'h8000, 16'h7fff);
      send_item(blank_item(OPC_TICK));
      send_item(blank_item(OPC_SPARE_A));
      send_item(blank_item(OPC_SPARE_B));
      send_button(2'd3, 1'b1);                           // ignored index
      send_item(blank_item(OPC_TICK));
      wait_idle();
   endtask

   task automatic test_mouse_relative();
      write_csr(CSR_MOUSE_REL, 8'h01);
      send_bus(4'h3, CMD_LISTEN, 2'd3, 8'h00, 8'd2);
      send_move(16'h7fff, 16'h8000);
      send_move(16'h7fff, 16'h8000);                     // wraps
      send_button(2'd2, 1'b1);
      send_item(blank_item(OPC_TICK));
      send_move(16'hffff, 16'h0001);
      send_button(2'd1, 1'b1);
      send_button(2'd2, 1'b0);
      send_item(blank_item(OPC_TICK));
      send_bus(4'h3, CMD_LISTEN, 2'd3, 8'h00, 8'd4);
      send_button(2'd0, 1'b0);
      send_item(blank_item(OPC_TICK));
      send_item(blank_item(OPC_TICK));
      wait_idle();
   endtask

   function automatic item_type random_item();
      item_type it;
      logic [3:0] adrs [4];
      int p;
      it.opcode        = 3'($urandom_range(5));
      it.command_byte  = 8'($urandom);
      it.listen_byte1  = 8'($urandom);
      it.listen_byte2  = 8'($urandom);
      it.random_nibble = 4'($urandom);
      it.key_code      = 7'($urandom);
      it.button_index  = 2'($urandom);
      it.pressed       = 1'($urandom);
      it.move_x        = 16'($urandom);
      it.move_y        = 16'($urandom);
      p = $urandom_range(99);
      if (p < 3) it.opcode = 3'($urandom_range(6, 7));
      else if (p < 25) it.opcode = OPC_BUS;
      else if (p < 38) it.opcode = OPC_TICK;
      // Mostly aim at devices that exist, with sensible listen data.
      if (it.opcode == OPC_BUS && $urandom_range(9) < 8) begin
         adrs = '{mouse_addr[3:0], kbd_addr[3:0], 4'h2, 4'h3};
         it.command_byte[7:4] = adrs[$urandom_range(3)];
         if ($urandom_range(2) != 0) it.command_byte[3:2] = CMD_TALK;
         case ($urandom_range(5))
            0: it.listen_byte2 = 8'hfe;
            1: it.listen_byte2 = 8'h00;
            2: it.listen_byte2 = 8'd4;
            3: it.listen_byte2 = 8'($urandom_range(1, 2));
            default: ;
         endcase
      end
      if (it.opcode inside {OPC_KEYDOWN, OPC_KEYUP} && $urandom_range(3) == 0) begin
         adrs = '{4'h6, 4'h4, 4'h3, 4'h7};
         it.key_code = {3'($urandom_range(3, 7)), adrs[$urandom_range(3)]};
      end
      if (it.opcode == OPC_MOVE && $urandom_range(1))
         it.move_x = 16'($signed(8'($urandom)));
      return it;
   endfunction

   task automatic test_random(int count, bit bursts);
      for (int i = 0; i < count; i++)
         send_item(random_item(), !bursts || (i % 40) >= 20);
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OPC_BUS;
      req_command_byte = '0;
      req_listen_byte1 = '0;
      req_listen_byte2 = '0;
      req_random_nibble = '0;
      req_key_code = '0;
      req_button_index = '0;
      req_pressed = 1'b0;
      req_move_x = '0;
      req_move_y = '0;
      csr_valid = 1'b0;
      csr_index = CSR_KBD_TYPE;
      csr_data = '0;
      error_count = 0;
      kbd_type = 8'd5;
      mouse_rel = 1'b0;
      restore_device_regs();
      keys_down = '0;
      mouse_x = 0;
      mouse_y = 0;
      last_x = 0;
      last_y = 0;
      buttons_now = 0;
      buttons_reported = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_bus_commands();
      test_key_fifo();
      test_mouse_relative();
      write_csr(CSR_KBD_TYPE, 8'hff);
      test_random(95, 1'b1);
      write_csr(CSR_MOUSE_REL, 8'h00);
      write_csr(CSR_KBD_TYPE, 8'h00);
      test_random(95, 1'b0);
      write_csr(CSR_MOUSE_REL, 8'h01);
      write_csr(CSR_KBD_TYPE, 8'($urandom));
      test_random(95, 1'b1);
      write_csr(CSR_MOUSE_REL, 8'h00);
      write_csr(CSR_KBD_TYPE, 8'd5);
      test_random(100, 1'b0);

      if (expected_reports.size() != 0) begin
         $error("%0d expected results never arrived", expected_reports.size());
         error_count++;
      end
      if (error_count == 0)
         $display("adb_mouse_keyboard_device_test: PASS");
      else
         $display("adb_mouse_keyboard_device_test: FAIL");
      $finish;
   end

   // Watchdog.
   initial begin
      #4000000;
      $display("adb_mouse_keyboard_device_test: FAIL");
      $finish;
   end

endmodule

// ===== adb_mouse_keyboard_device.f =====
rtl/adb_pkg.sv
rtl/adb_front.sv
rtl/adb_back.sv
rtl/adb_ram.sv
rtl/adb_mouse_keyboard_device.sv
tb/adb_mouse_keyboard_device_test.sv
